[design/urk_pkg.sv]
`default_nettype none

package urk_pkg;

    localparam int FRAC_BITS = 16;

    localparam int WIDTH_W = 16;
    localparam int DIST_W  = 25;
    localparam int VAR_W   = 32;
    localparam int STAT_W  = 2;
    localparam int GAIN_W  = FRAC_BITS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_EST  = 3'd4;

    localparam logic [WIDTH_W-1:0] TIMEOUT_RST    = 16'd26000;
    localparam logic [VAR_W-1:0]   PROC_NOISE_RST = 32'd655;
    localparam logic [VAR_W-1:0]   MEAS_NOISE_RST = 32'd6554;
    localparam logic [VAR_W-1:0]   INIT_VAR_RST   = 32'd65536;
    localparam logic [DIST_W-1:0]  INIT_EST_RST   = 25'd0;

    localparam logic [WIDTH_W-1:0] MIN_WIDTH_US = 16'd116;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_US = 16'd23200;
    localparam int                 SPEED_DIV    = 58;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

    // gain divider: one quotient bit per step
    localparam int QLO_W   = FRAC_BITS + 1;
    localparam int K_STEPS = FRAC_BITS + 1;
    localparam int CNT_W   = $clog2(K_STEPS + 1);
    localparam int REM_W   = VAR_W + 1;

    // measurement (w << FRAC_BITS) / 58 as (w * MEAS_RECIP) >> MEAS_SHIFT,
    // exact for w < 2^15 at FRAC_BITS = 16
    localparam int MEAS_SHIFT = 21;
    localparam int MEAS_W     = WIDTH_W + VAR_W;
    localparam logic [VAR_W-1:0] MEAS_RECIP =
        VAR_W'(((64'd1 << (MEAS_SHIFT + FRAC_BITS)) + 64'(SPEED_DIV) - 64'd1)
               / 64'(SPEED_DIV));

    // microcode
    localparam int PC_W = 4;
    localparam int OP_W = 4;
    localparam int CD_W = 3;

    localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
    localparam logic [OP_W-1:0] OP_WAIT  = 4'd1;
    localparam logic [OP_W-1:0] OP_CHECK = 4'd2;
    localparam logic [OP_W-1:0] OP_LDM   = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
    localparam logic [OP_W-1:0] OP_LDK   = 4'd5;
    localparam logic [OP_W-1:0] OP_GAIN  = 4'd6;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd7;
    localparam logic [OP_W-1:0] OP_UPD   = 4'd8;
    localparam logic [OP_W-1:0] OP_EMIT  = 4'd9;

    localparam logic [CD_W-1:0] C_NEXT     = 3'd0;
    localparam logic [CD_W-1:0] C_ALWAYS   = 3'd1;
    localparam logic [CD_W-1:0] C_NO_IN    = 3'd2;
    localparam logic [CD_W-1:0] C_ERR      = 3'd3;
    localparam logic [CD_W-1:0] C_DIV_MORE = 3'd4;
    localparam logic [CD_W-1:0] C_OUT_BUSY = 3'd5;

    localparam logic [PC_W-1:0] S_WAIT  = 4'd0;
    localparam logic [PC_W-1:0] S_CHECK = 4'd1;
    localparam logic [PC_W-1:0] S_LDM   = 4'd2;
    localparam logic [PC_W-1:0] S_LDK   = 4'd3;
    localparam logic [PC_W-1:0] S_DIVK  = 4'd4;
    localparam logic [PC_W-1:0] S_GAIN  = 4'd5;
    localparam logic [PC_W-1:0] S_MUL   = 4'd6;
    localparam logic [PC_W-1:0] S_UPD   = 4'd7;
    localparam logic [PC_W-1:0] S_EMIT  = 4'd8;
    localparam logic [PC_W-1:0] S_LOOP  = 4'd9;
    localparam logic [PC_W-1:0] ROM_LEN = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [CD_W-1:0] cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_WAIT};
        case (pc)
            S_WAIT:  w = '{op: OP_WAIT,  cond: C_NO_IN,    target: S_WAIT};
            S_CHECK: w = '{op: OP_CHECK, cond: C_ERR,      target: S_EMIT};
            S_LDM:   w = '{op: OP_LDM,   cond: C_NEXT,     target: S_WAIT};
            S_LDK:   w = '{op: OP_LDK,   cond: C_NEXT,     target: S_WAIT};
            S_DIVK:  w = '{op: OP_DIV,   cond: C_DIV_MORE, target: S_DIVK};
            S_GAIN:  w = '{op: OP_GAIN,  cond: C_NEXT,     target: S_WAIT};
            S_MUL:   w = '{op: OP_MUL,   cond: C_NEXT,     target: S_WAIT};
            S_UPD:   w = '{op: OP_UPD,   cond: C_NEXT,     target: S_WAIT};
            S_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY, target: S_EMIT};
            S_LOOP:  w = '{op: OP_NOP,   cond: C_ALWAYS,   target: S_WAIT};
            default: w = '{op: OP_NOP,   cond: C_ALWAYS,   target: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[design/ultrasonic_range_kalman_top.sv]
// Ultrasonic range filter: echo pulse width in, filtered distance out.
//
// Input channel in_valid/in_ready carries one word, pulse_width_us. Output
// channel out_valid/out_ready carries distance_cm_q16 (Q9.16 cm) and status
// (0 ok, 1 timeout or no echo, 2 out of range; distance 0 on error).
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data is always
// ready; index 3 and 4 also reload the filter variance and estimate.
//
// Control is a microcode table stepped by a program counter; one word is in
// work at a time. After acceptance a valid reading is checked, one reciprocal
// multiply gives the measurement, a restoring divider producing one quotient
// bit per cycle runs 17 steps for the gain, then one multiply stage and the
// update lead to out_valid. An error reading goes from the check straight to
// the emit step.
//
// The output register holds a finished word; the next input word is taken
// while it waits. If the receiver stalls, the sequencer waits at its emit
// step until the register is free. Reset restores the register defaults,
// estimate 0 and variance 1.0, and leaves no word pending.
`default_nettype none

module ultrasonic_range_kalman_top
    import urk_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [WIDTH_W-1:0]    pulse_width_us,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [DIST_W-1:0]          distance_cm_q16,
    output logic [STAT_W-1:0]          status,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [WIDTH_W-1:0] timeout_reg;
    logic [VAR_W-1:0]   q_reg;
    logic [VAR_W-1:0]   r_reg;

    // filter state
    logic [DIST_W-1:0]  estimate_reg, estimate_next;
    logic [VAR_W-1:0]   variance_reg, variance_next;

    // sequencer
    logic [PC_W-1:0]    pc_reg, pc_next;
    ctrl_t              ctrl;
    logic               jump;

    // datapath
    logic [WIDTH_W-1:0] width_reg;
    logic [VAR_W-1:0]   p1_reg;
    logic [DIST_W-1:0]  m_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [QLO_W-1:0]   qlo_reg;
    logic [REM_W-1:0]   div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               den_zero_reg;
    logic [GAIN_W-1:0]  k_reg;
    logic [GAIN_W:0]    omk_reg;
    logic [DIST_W-1:0]  diff_reg;
    logic               up_reg;
    logic [DIST_W+GAIN_W-1:0]  prod_x_reg;
    logic [VAR_W+GAIN_W:0]     prod_p_reg;
    logic [DIST_W-1:0]  res_dist_reg;
    logic [STAT_W-1:0]  res_status_reg;

    // output slot
    logic               out_valid_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic [STAT_W-1:0]  out_status_reg;

    logic               in_fire;
    logic               cfg_fire;
    logic               out_free;
    logic [STAT_W-1:0]  err_code;
    logic [VAR_W:0]     p_sum;
    logic [VAR_W-1:0]   p1_sat;
    logic [REM_W:0]     trial;
    logic               trial_ge;
    logic [REM_W-1:0]   trial_sub;
    logic [REM_W-1:0]   den;
    logic [GAIN_W-1:0]  k_val;
    logic [MEAS_W-1:0]  meas_prod;
    logic [DIST_W-1:0]  mag;

    assign ctrl      = ucode_rom(pc_reg);
    assign in_ready  = (ctrl.op == OP_WAIT);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign distance_cm_q16 = out_dist_reg;
    assign status          = out_status_reg;

    always_comb
    begin
        if (width_reg == '0 || width_reg > timeout_reg)
            err_code = ST_TIMEOUT;
        else if (width_reg < MIN_WIDTH_US || width_reg > MAX_WIDTH_US)
            err_code = ST_RANGE;
        else
            err_code = ST_OK;
    end

    assign p_sum     = {1'b0, variance_reg} + {1'b0, q_reg};
    assign p1_sat    = p_sum[VAR_W] ? '1 : p_sum[VAR_W-1:0];
    assign den       = {1'b0, p1_reg} + {1'b0, r_reg};
    assign meas_prod = width_reg * MEAS_RECIP;

    // one restoring-division step
    assign trial     = {rem_reg, qlo_reg[QLO_W-1]};
    assign trial_ge  = trial >= {1'b0, div_reg};
    assign trial_sub = REM_W'(trial - {1'b0, div_reg});

    always_comb
    begin
        if (den_zero_reg)
            k_val = '0;
        else if (qlo_reg[GAIN_W])
            k_val = '1;
        else
            k_val = qlo_reg[GAIN_W-1:0];
    end

    assign mag = prod_x_reg[FRAC_BITS+DIST_W-1:FRAC_BITS];

    always_comb
    begin
        case (ctrl.cond)
            C_NEXT:     jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_IN:    jump = !in_fire;
            C_ERR:      jump = (err_code != ST_OK);
            C_DIV_MORE: jump = (cnt_reg != CNT_W'(1));
            C_OUT_BUSY: jump = !out_free;
            default:    jump = 1'b0;
        endcase
        pc_next = jump ? ctrl.target : PC_W'(pc_reg + 1'b1);
    end

    always_comb
    begin
        estimate_next = estimate_reg;
        variance_next = variance_reg;
        if (ctrl.op == OP_UPD)
        begin
            estimate_next = up_reg ? DIST_W'(estimate_reg + mag) : DIST_W'(estimate_reg - mag);
            variance_next = prod_p_reg[FRAC_BITS+VAR_W-1:FRAC_BITS];
        end
        if (cfg_fire && cfg_index == REG_INIT_VAR)
            variance_next = cfg_data[VAR_W-1:0];
        if (cfg_fire && cfg_index == REG_INIT_EST)
            estimate_next = cfg_data[DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RST;
            q_reg         <= PROC_NOISE_RST;
            r_reg         <= MEAS_NOISE_RST;
            estimate_reg  <= INIT_EST_RST;
            variance_reg  <= INIT_VAR_RST;
            pc_reg        <= S_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    REG_TIMEOUT:    timeout_reg  <= cfg_data[WIDTH_W-1:0];
                    REG_PROC_NOISE: q_reg        <= cfg_data[VAR_W-1:0];
                    REG_MEAS_NOISE: r_reg        <= cfg_data[VAR_W-1:0];
                    // initial values only reload the filter state
                    REG_INIT_VAR, REG_INIT_EST: ;
                    default:        ;
                endcase
            end
            estimate_reg <= estimate_next;
            variance_reg <= variance_next;
            pc_reg       <= pc_next;
            if (ctrl.op == OP_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_WAIT:
            begin
                if (in_fire)
                    width_reg <= pulse_width_us;
            end
            OP_CHECK:
            begin
                res_status_reg <= err_code;
                res_dist_reg   <= '0;
                p1_reg         <= p1_sat;
            end
            OP_LDM:
            begin
                m_reg <= meas_prod[MEAS_SHIFT+DIST_W-1:MEAS_SHIFT];
            end
            OP_DIV:
            begin
                rem_reg <= trial_ge ? trial_sub : trial[REM_W-1:0];
                qlo_reg <= {qlo_reg[QLO_W-2:0], trial_ge};
                cnt_reg <= CNT_W'(cnt_reg - 1'b1);
            end
            OP_LDK:
            begin
                rem_reg      <= REM_W'(p1_reg[VAR_W-1:1]);
                qlo_reg      <= {p1_reg[0], {(QLO_W-1){1'b0}}};
                div_reg      <= den;
                den_zero_reg <= (den == '0);
                cnt_reg      <= CNT_W'(K_STEPS);
            end
            OP_GAIN:
            begin
                k_reg    <= k_val;
                omk_reg  <= (GAIN_W+1)'(1 << FRAC_BITS) - {1'b0, k_val};
                up_reg   <= (m_reg >= estimate_reg);
                diff_reg <= (m_reg >= estimate_reg) ? DIST_W'(m_reg - estimate_reg)
                                                    : DIST_W'(estimate_reg - m_reg);
            end
            OP_MUL:
            begin
                prod_x_reg <= diff_reg * k_reg;
                prod_p_reg <= omk_reg * p1_reg;
            end
            OP_UPD:
            begin
                res_dist_reg   <= estimate_next;
                res_status_reg <= ST_OK;
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_dist_reg   <= res_dist_reg;
                    out_status_reg <= res_status_reg;
                end
            end
            default: ;
        endcase
    end

    a_err_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> distance_cm_q16 == '0)
        else $error("error word with nonzero distance");

    a_pc_in_rom: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg < ROM_LEN)
        else $error("sequencer left the microcode table");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_DIV |-> cnt_reg != '0)
        else $error("divider stepped with empty count");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> pc_reg == S_CHECK)
        else $error("accepted word not checked next");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_EMIT && out_free |=> out_valid_reg && pc_reg == S_LOOP)
        else $error("emit did not fill output slot");

endmodule

`default_nettype wire

[sim/range_filter_checker.sv]
module range_filter_checker
    import urk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [WIDTH_W-1:0]    pulse_width_us,

    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [DIST_W-1:0]     distance_cm_q16,
    input  logic [STAT_W-1:0]     status,

    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    output int                    fail_count,
    output int                    pending,
    output int                    checked
);

    localparam logic [63:0] ONE     = 64'd1 << FRAC_BITS;
    localparam logic [63:0] VAR_MAX = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [DIST_W-1:0] dist_cm;
        logic [STAT_W-1:0] stat;
    } range_word_t;

    range_word_t expected_words[$];

    logic [WIDTH_W-1:0] cfg_timeout;
    logic [VAR_W-1:0]   cfg_q;
    logic [VAR_W-1:0]   cfg_r;
    logic [DIST_W-1:0]  est_dist;
    logic [VAR_W-1:0]   est_var;

    // one filter step on an echo width; updates est_dist/est_var on a good reading
    function automatic range_word_t filter_width(input logic [WIDTH_W-1:0] w);
        range_word_t res;
        logic [63:0] meas, p1, den, gain, mag, x, pn;
        res.dist_cm = '0;
        if (w == '0 || w > cfg_timeout)
        begin
            res.stat = ST_TIMEOUT;
        end
        else if (w < MIN_WIDTH_US || w > MAX_WIDTH_US)
        begin
            res.stat = ST_RANGE;
        end
        else
        begin
            meas = ({48'd0, w} << FRAC_BITS) / 64'(SPEED_DIV);
            p1 = {32'd0, est_var} + {32'd0, cfg_q};
            if (p1 > VAR_MAX)
                p1 = VAR_MAX;
            den = p1 + {32'd0, cfg_r};
            gain = (den == 64'd0) ? 64'd0 : (p1 << FRAC_BITS) / den;
            if (gain > ONE - 64'd1)
                gain = ONE - 64'd1;
            x = {39'd0, est_dist};
            if (meas >= x)
            begin
                mag = ((meas - x) * gain) >> FRAC_BITS;
                x = x + mag;
            end
            else
            begin
                mag = ((x - meas) * gain) >> FRAC_BITS;
                x = x - mag;
            end
            pn = ((ONE - gain) * p1) >> FRAC_BITS;
            est_dist = x[DIST_W-1:0];
            est_var = pn[VAR_W-1:0];
            res.dist_cm = est_dist;
            res.stat = ST_OK;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        range_word_t want;
        int errs;
        int seen;
        if (!rst_n)
        begin
            cfg_timeout = TIMEOUT_RST;
            cfg_q = PROC_NOISE_RST;
            cfg_r = MEAS_NOISE_RST;
            est_var = INIT_VAR_RST;
            est_dist = INIT_EST_RST;
            expected_words.delete();
            fail_count <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            errs = 0;
            seen = 0;
            if (out_valid && out_ready)
            begin
                seen = 1;
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got %0d status %0d",
                             $time, distance_cm_q16, status);
                    errs++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (distance_cm_q16 !== want.dist_cm)
                    begin
                        $display("%0t: distance mismatch, expected %0d got %0d",
                                 $time, want.dist_cm, distance_cm_q16);
                        errs++;
                    end
                    if (status !== want.stat)
                    begin
                        $display("%0t: status mismatch, expected %0d got %0d",
                                 $time, want.stat, status);
                        errs++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TIMEOUT:    cfg_timeout = cfg_data[WIDTH_W-1:0];
                    REG_PROC_NOISE: cfg_q = cfg_data;
                    REG_MEAS_NOISE: cfg_r = cfg_data;
                    REG_INIT_VAR:   est_var = cfg_data;
                    REG_INIT_EST:   est_dist = cfg_data[DIST_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_words.push_back(filter_width(pulse_width_us));
            fail_count <= fail_count + errs;
            checked <= checked + seen;
            pending <= expected_words.size();
        end
    end

endmodule

[sim/ultrasonic_range_kalman_top_test.sv]
module ultrasonic_range_kalman_top_test;
    import urk_pkg::*;

    localparam int RANDOM_WORDS = 1944;
    localparam int SUB_PHASES   = 3;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 60;
    localparam logic [DIST_W-1:0] DIST_MAX = 25'd26214400;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = 16'hFFFF;
    localparam logic [VAR_W-1:0] VAR_MAX = 32'hFFFF_FFFF;

    localparam logic [WIDTH_W-1:0] EDGE_WIDTHS [11] = '{
        16'd0, 16'd1, 16'd115, 16'd116, 16'd117, 16'd23200, 16'd23201,
        16'd26000, 16'd26001, 16'hFFFF, 16'h5555
    };

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [WIDTH_W-1:0]    pulse_width_us;
    logic                  out_valid;
    logic                  out_ready;
    logic [DIST_W-1:0]     distance_cm_q16;
    logic [STAT_W-1:0]     status;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int checked;

    int sender_idle;
    int receiver_idle;
    int hold_asks;
    int words_sent;
    int settings_used;
    logic [WIDTH_W-1:0] cur_timeout;

    ultrasonic_range_kalman_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pulse_width_us(pulse_width_us),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .distance_cm_q16(distance_cm_q16),
        .status(status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    range_filter_checker check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pulse_width_us(pulse_width_us),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .distance_cm_q16(distance_cm_q16),
        .status(status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .fail_count(fail_count),
        .pending(pending),
        .checked(checked)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    // result side: random stalls, plus long hold-offs on request
    initial
    begin : receiver
        int hold_seen;
        hold_seen = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                out_ready <= ($urandom_range(0, 99) >= receiver_idle);
            end
        end
    end

    task automatic send_width(input logic [WIDTH_W-1:0] w);
        if ($urandom_range(0, 99) < sender_idle) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < sender_idle);
        end
        in_valid <= 1'b1;
        pulse_width_us <= w;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [WIDTH_W-1:0] t, input logic [VAR_W-1:0] q,
                                 input logic [VAR_W-1:0] r, input logic [VAR_W-1:0] v,
                                 input logic [DIST_W-1:0] e);
        write_reg(REG_TIMEOUT, {16'd0, t});
        write_reg(REG_PROC_NOISE, q);
        write_reg(REG_MEAS_NOISE, r);
        write_reg(REG_INIT_VAR, v);
        write_reg(REG_INIT_EST, {7'd0, e});
        // unused index, must be ignored
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_IDX_W'($urandom_range(REG_INIT_EST + 1, 2**CFG_IDX_W - 1)), $urandom);
        cfg_valid <= 1'b0;
        cur_timeout = t;
        settings_used++;
    endtask

    function automatic logic [VAR_W-1:0] noise_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1023);
            1: return $urandom_range(0, 1 << 20);
            2: return $urandom;
            default: return VAR_MAX - $urandom_range(0, 3);
        endcase
    endfunction

    task automatic random_settings();
        logic [WIDTH_W-1:0] t;
        case ($urandom_range(0, 3))
            0: t = TIMEOUT_RST;
            1: t = MAX_WIDTH_US;
            2: t = WIDTH_MAX;
            default: t = WIDTH_W'($urandom_range(0, 65535));
        endcase
        load_settings(t, noise_value(), noise_value(), noise_value(),
                      DIST_W'($urandom_range(0, DIST_MAX)));
    endtask

    function automatic logic [WIDTH_W-1:0] random_width();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 78)
            return WIDTH_W'($urandom_range(MIN_WIDTH_US, MAX_WIDTH_US));
        if (pick < 81)
            return '0;
        if (pick < 87)
            return WIDTH_W'($urandom_range(1, MIN_WIDTH_US - 1));
        if (pick < 93)
            return WIDTH_W'($urandom_range(MAX_WIDTH_US + 1, 65535));
        if (pick < 96)
            return cur_timeout + WIDTH_W'($urandom_range(0, 2)) - 16'd1;
        return WIDTH_W'($urandom);
    endfunction

    initial
    begin : stimulus
        int mode;
        int sub;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        pulse_width_us <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        sender_idle = 21;
        receiver_idle = 81;
        hold_asks <= 0;
        words_sent = 0;
        settings_used = 1;
        cur_timeout = TIMEOUT_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (EDGE_WIDTHS[i])
            send_width(EDGE_WIDTHS[i]);
        drain();

        // zero denominator, gain stays 0
        load_settings(WIDTH_MAX, '0, '0, '0, DIST_MAX);
        send_width(16'd116);
        send_width(16'd23200);
        send_width(16'hFFFF);
        send_width(16'd23201);
        send_width(16'd1);
        drain();

        // gain saturates just below one
        load_settings(WIDTH_MAX, 32'd1, '0, '0, '0);
        send_width(16'd23200);
        send_width(16'd116);
        send_width(16'd12000);
        drain();

        // variance sum saturates
        load_settings(MAX_WIDTH_US, VAR_MAX, VAR_MAX, VAR_MAX, DIST_MAX);
        send_width(16'd23200);
        send_width(16'd23201);
        send_width(16'd116);
        send_width(16'd4000);
        drain();

        // zero timeout: every width times out
        load_settings('0, PROC_NOISE_RST, MEAS_NOISE_RST, INIT_VAR_RST, INIT_EST_RST);
        send_width(16'd0);
        send_width(16'd116);
        drain();

        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin sender_idle = 21; receiver_idle = 81; end
                1: begin sender_idle = 81; receiver_idle = 21; end
                default: begin sender_idle = 0; receiver_idle = 0; end
            endcase
            for (sub = 0; sub < SUB_PHASES; sub++) begin
                random_settings();
                if (mode == 2 && sub == 0)
                    hold_asks <= hold_asks + 1;
                repeat (RANDOM_WORDS / (3 * SUB_PHASES))
                    send_width(random_width());
                drain();
            end
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d pulse widths under %0d filter settings, %0d result words checked",
                 words_sent, settings_used, checked);
        $display("Covered no echo, timeout, out of range, zero and saturated gain, %0d-cycle stall",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
